// ----- rtl/core/sliding_window_min_max_top_assert.svh -----
// assertion macros for the sliding window min/max block
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset only
`define SWMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset only
`define SWMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/swmm_pkg.sv -----
// shared types and constants of the sliding window min/max block
// no dependencies
package swmm_pkg;

  localparam int WinMax     = 64;
  localparam int SampleBits = 16;
  localparam int CfgBits    = 7;
  localparam int LenBits    = $clog2(WinMax + 1);
  localparam int CellCount  = WinMax - 1;
  localparam int IdxBits    = (CellCount > 1) ? $clog2(CellCount) : 1;
  localparam int LenReset   = 8;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [CfgBits-1:0]           cfg_len_t;
  typedef logic [LenBits-1:0]           len_t;
  typedef logic [IdxBits-1:0]           idx_t;

  // running extremes held by one cell
  typedef struct packed {
    sample_t lo;
    sample_t hi;
  } pair_t;

  // control handed from the sequencer to the datapath
  typedef struct packed {
    logic step;     // request accepted this cycle
    logic emit;     // this request completes a window
    logic len_one;  // window of a single sample
    idx_t tap_idx;  // cell holding the extremes of the older len-1 samples
  } ctrl_t;

endpackage

// ----- rtl/core/swmm_if.sv -----
// valid/ready channels of the sliding window min/max block
// depends on swmm_pkg
interface swmm_cfg_if;
  import swmm_pkg::*;
  logic     valid;
  logic     ready;
  cfg_len_t window_len;
  modport source (output valid, output window_len, input ready);
  modport sink (input valid, input window_len, output ready);
endinterface

interface swmm_in_if;
  import swmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    restart;
  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface swmm_out_if;
  import swmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t window_min;
  sample_t window_max;
  modport source (output valid, output window_min, output window_max, input ready);
  modport sink (input valid, input window_min, input window_max, output ready);
endinterface

// ----- rtl/core/swmm_cell.sv -----
// one cell of the extremes chain: min and max of its neighbour and the new sample
// depends on swmm_pkg
module swmm_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  swmm_pkg::sample_t sample_i,
  input  swmm_pkg::pair_t prev_i,
  output swmm_pkg::pair_t cur_o
);
  import swmm_pkg::*;

  pair_t cur_q;
  pair_t cur_d;

  always_comb begin
    cur_d.lo = (prev_i.lo < sample_i) ? prev_i.lo : sample_i;
    cur_d.hi = (prev_i.hi > sample_i) ? prev_i.hi : sample_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cur_q <= cur_d;
    end
  end

  assign cur_o = cur_q;

endmodule

// ----- rtl/core/swmm_ctrl.sv -----
// sequencer: window length register, fill count and handshake of the block
// depends on swmm_pkg
module swmm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  swmm_pkg::cfg_len_t cfg_len_i,
  output logic               cfg_ready_o,
  input  logic               in_valid_i,
  input  logic               in_restart_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output swmm_pkg::ctrl_t    ctrl_o
);
  import swmm_pkg::*;

  cfg_len_t len_q;
  len_t     fill_q, fill_d;
  logic     out_valid_q, out_valid_d;
  len_t     len_eff, len_m1, fill_base, fill_new;
  logic     step, emit;

  // zero acts as one, oversize saturates
  always_comb begin
    if (len_q == '0) begin
      len_eff = len_t'(1);
    end else if (int'(len_q) > WinMax) begin
      len_eff = len_t'(WinMax);
    end else begin
      len_eff = len_t'(len_q);
    end
  end

  assign len_m1     = len_eff - len_t'(1);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;
  assign fill_base  = in_restart_i ? '0 : fill_q;
  assign fill_new   = ((fill_base > len_m1) ? len_m1 : fill_base) + len_t'(1);
  assign emit       = (fill_new == len_eff);
  assign fill_d     = emit ? len_m1 : fill_new;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= cfg_len_t'(LenReset);
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        len_q <= cfg_len_i;
      end
      if (step) begin
        fill_q <= fill_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign ctrl_o.step    = step;
  assign ctrl_o.emit    = emit;
  assign ctrl_o.len_one = (len_eff == len_t'(1));
  assign ctrl_o.tap_idx = idx_t'(len_eff - len_t'(2));

endmodule

// ----- rtl/core/sliding_window_min_max_top.sv -----
// top level of the sliding window min/max block
// depends on swmm_pkg, swmm_if, swmm_cell, swmm_ctrl and the assertion header
//
// Gives the minimum and maximum of the last window_len signed samples of a
// stream. The row of cells updates in the cycle of acceptance and the
// result, if the request completes a window, sits in the output register
// from the next cycle. A new request is taken in every cycle in which the
// output register is empty or being drained, so one sample per clock is
// sustained without back-pressure. Cell k holds the min and max of the
// newest k+1 samples; on each request every cell folds the new sample into
// the value of its neighbour, so no deque or window store is needed. A
// result is given once window_len samples have arrived since the last
// restart (after the window grew, at most the old window_len-1 samples from
// before count); shrinking the window takes effect on the next request.
// window_len of zero acts as one, values above 64 act as 64. Configuration
// writes are always taken and should only be made while the block is idle.
`include "sliding_window_min_max_top_assert.svh"

module sliding_window_min_max_top (
  input  logic    clk_i,
  input  logic    rst_ni,
  swmm_cfg_if.sink cfg_i,
  swmm_in_if.sink in_i,
  swmm_out_if.source out_o
);
  import swmm_pkg::*;

  ctrl_t   ctrl;
  pair_t   cells [CellCount];
  pair_t   seed;
  pair_t   tap;
  sample_t res_min, res_max;
  sample_t min_q, max_q;

  // sequencing, fill tracking and handshakes
  swmm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_len_i    (cfg_i.window_len),
    .cfg_ready_o  (cfg_i.ready),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .in_ready_o   (in_i.ready),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .ctrl_o       (ctrl)
  );

  // first cell sees the sample as its own neighbour
  assign seed.lo = in_i.sample;
  assign seed.hi = in_i.sample;

  for (genvar g = 0; g < CellCount; g++) begin : g_cell
    if (g == 0) begin : g_head
      swmm_cell u_cell (
        .clk_i    (clk_i),
        .en_i     (ctrl.step),
        .sample_i (in_i.sample),
        .prev_i   (seed),
        .cur_o    (cells[g])
      );
    end else begin : g_body
      swmm_cell u_cell (
        .clk_i    (clk_i),
        .en_i     (ctrl.step),
        .sample_i (in_i.sample),
        .prev_i   (cells[g-1]),
        .cur_o    (cells[g])
      );
    end
  end

  // extremes of the older len-1 samples, folded with the new one
  assign tap     = ctrl.len_one ? seed : cells[ctrl.tap_idx];
  assign res_min = (tap.lo < in_i.sample) ? tap.lo : in_i.sample;
  assign res_max = (tap.hi > in_i.sample) ? tap.hi : in_i.sample;

  // output register, loaded only by a request that completes a window
  always_ff @(posedge clk_i) begin
    if (ctrl.step && ctrl.emit) begin
      min_q <= res_min;
      max_q <= res_max;
    end
  end

  assign out_o.window_min = min_q;
  assign out_o.window_max = max_q;

  // a completed window always shows up as a result in the next cycle
  `SWMM_ASSERT_NXT(a_emit_shows, ctrl.step && ctrl.emit, out_o.valid, "result lost")
  // a request that completes no window leaves no result behind
  `SWMM_ASSERT_NXT(a_no_phantom, ctrl.step && !ctrl.emit, !out_o.valid, "result invented")
  // after a restart only a single-sample window can be complete
  `SWMM_ASSERT_IMP(a_restart_fill, ctrl.step && in_i.restart && !ctrl.len_one, !ctrl.emit, "restart ignored")
  // head cell always holds the most recent request's sample
  `SWMM_ASSERT_NXT(a_head_cell, ctrl.step, cells[0].hi == $past(in_i.sample), "head cell stale")

endmodule

// ----- verif/sliding_window_min_max_top_tb.sv -----
`timescale 1ns / 1ps
// testbench of the sliding window min/max block: directed and random sample
// requests against a window predictor, with random stalls on both channels
// depends on swmm_pkg, swmm_if and sliding_window_min_max_top
module sliding_window_min_max_top_tb;
  import swmm_pkg::*;

  localparam int ClkPeriod      = 20;
  localparam int ResetCycles    = 11;
  localparam int SettleCycles   = 8;       // result register is loaded in the cycle after a request
  localparam int LongHoldCycles = 150;
  localparam int ItemsPerPhase  = 100;
  localparam int PhaseCount     = 14;
  localparam int ReportLimit    = 10;
  localparam longint TimeoutNs  = 64'd4_000_000;

  // window predictor: holds the samples still inside the window and the
  // min/max pairs that the block still owes
  class window_extremes_board;
    sample_t     recent_samples[$];
    pair_t       owed_extremes[$];
    int unsigned span;
    int unsigned failures;

    function new();
      span     = LenReset;
      failures = 0;
    endfunction

    // zero acts as one, anything above the store depth saturates
    function void set_window_len(cfg_len_t value);
      if (value == 0) begin
        span = 1;
      end else if (value > WinMax) begin
        span = WinMax;
      end else begin
        span = int'(value);
      end
    endfunction

    function int unsigned pending();
      return owed_extremes.size();
    endfunction

    function void note_failure(string what);
      failures++;
      if (failures <= ReportLimit) begin
        $display("%s", what);
      end
    endfunction

    // one accepted sample request
    function void note_sample(sample_t value, logic restart_flag);
      sample_t lo;
      sample_t hi;
      pair_t   owed;
      if (restart_flag) begin
        recent_samples.delete();
      end
      // a shrunk window drops its oldest samples before the push
      while (recent_samples.size() >= span) begin
        recent_samples.delete(0);
      end
      recent_samples = {recent_samples, value};
      if (recent_samples.size() >= span) begin
        lo = value;
        hi = value;
        foreach (recent_samples[i]) begin
          if (recent_samples[i] < lo) begin
            lo = recent_samples[i];
          end
          if (recent_samples[i] > hi) begin
            hi = recent_samples[i];
          end
        end
        owed.lo = lo;
        owed.hi = hi;
        owed_extremes = {owed_extremes, owed};
        recent_samples.delete(0);
      end
    endfunction

    // one accepted result against the oldest owed pair
    function void check_extremes(sample_t got_min, sample_t got_max);
      pair_t want;
      if (owed_extremes.size() == 0) begin
        note_failure($sformatf("unexpected result: min %0d max %0d", got_min, got_max));
        return;
      end
      want = owed_extremes[0];
      owed_extremes.delete(0);
      if (want.lo !== got_min) begin
        note_failure($sformatf("window_min mismatch: expected %0d got %0d",
                               $signed(want.lo), got_min));
      end
      if (want.hi !== got_max) begin
        note_failure($sformatf("window_max mismatch: expected %0d got %0d",
                               $signed(want.hi), got_max));
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // idling controls, set by the main process; hold_done by the result side
  logic feed_no_gaps  = 1'b0;
  logic drain_no_gaps = 1'b0;
  logic hold_off_req  = 1'b0;
  logic hold_done     = 1'b0;

  window_extremes_board board = new();

  // directed requests, {restart, sample}, taken at the reset window length of 8
  logic [16:0] directed_requests [22] = '{
    {1'b1, 16'h8000}, {1'b0, 16'h7FFF}, {1'b0, 16'h0000}, {1'b0, 16'hFFFF},
    {1'b0, 16'h0001}, {1'b0, 16'h8000}, {1'b0, 16'h8000}, {1'b0, 16'h7FFF},
    {1'b0, 16'h7FFF}, {1'b0, 16'h0005}, {1'b0, 16'h0005}, {1'b0, 16'h0005},
    {1'b0, 16'h5555}, {1'b0, 16'hAAAA}, {1'b0, 16'h0005}, {1'b0, 16'h0005},
    {1'b0, 16'h0005}, {1'b0, 16'h0005}, {1'b1, 16'h0064}, {1'b0, 16'hFF9C},
    {1'b0, 16'h0003}, {1'b1, 16'h0007}
  };

  // window lengths of the first phases: extremes, saturation, shrink and grow
  cfg_len_t fixed_lens [8] = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd65, 7'd5, 7'd2, 7'd3};

  swmm_cfg_if cfg_if ();
  swmm_in_if  in_if ();
  swmm_out_if out_if ();

  sliding_window_min_max_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // monitor: every handshake is sampled on the rising edge, before the
  // drivers' nonblocking updates of the same step land
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        board.set_window_len(cfg_if.window_len);
      end
      if (out_if.valid && out_if.ready) begin
        board.check_extremes(out_if.window_min, out_if.window_max);
      end
      if (in_if.valid && in_if.ready) begin
        board.note_sample(in_if.sample, in_if.restart);
      end
    end
  end

  // offer one sample request after a random gap and hold it until taken
  task automatic send_sample(input sample_t value, input logic restart_flag);
    int unsigned gap;
    gap = feed_no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.sample  <= value;
    in_if.restart <= restart_flag;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // pause until nothing is owed, then let the result register drain
  task automatic wait_idle();
    do @(posedge clk); while (board.pending() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // register writes only happen with the block idle
  task automatic write_window_len(input cfg_len_t value);
    in_if.valid <= 1'b0;
    wait_idle();
    cfg_if.valid      <= 1'b1;
    cfg_if.window_len <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // accept one result after a random stall; once per run a long hold-off
  // lets the output fill and back-pressure the sample channel
  task automatic take_result();
    int unsigned stall;
    if (hold_off_req && !hold_done) begin
      hold_done = 1'b1;
      out_if.ready <= 1'b0;
      repeat (LongHoldCycles) @(posedge clk);
    end else begin
      stall = drain_no_gaps ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
    out_if.ready <= 1'b1;
    do @(posedge clk); while (!out_if.valid);
  endtask

  // result side
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever take_result();
  end

  // sample and configuration side
  initial begin
    cfg_len_t len_value;
    sample_t  value;
    logic     restart_flag;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.restart     <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.window_len <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset length: extremes, ties between equal samples,
    // a restart on a partly filled window
    foreach (directed_requests[i]) begin
      send_sample(sample_t'(directed_requests[i][15:0]), directed_requests[i][16]);
    end

    // random phases; most keep the held samples, so length changes shrink or
    // grow a live window
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 8) begin
        len_value = fixed_lens[p];
      end else begin
        len_value = cfg_len_t'($urandom_range(0, 127));
      end
      write_window_len(len_value);
      feed_no_gaps  = ($urandom_range(0, 3) == 0);
      drain_no_gaps = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        // single-sample window, back-to-back requests against a stalled output
        feed_no_gaps = 1'b1;
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        case ($urandom_range(0, 7))
          0, 1: value = sample_t'($urandom_range(0, 6)) - sample_t'(3);
          2: value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          default: value = sample_t'($urandom());
        endcase
        restart_flag = ($urandom_range(0, 49) == 0);
        send_sample(value, restart_flag);
      end
    end

    in_if.valid <= 1'b0;
    wait_idle();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TimeoutNs);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
